// File: hw/rtl/max_front_deque_unit_defines.svh
// Assertion macros for the files that check their own logic.
`ifndef MAX_FRONT_DEQUE_UNIT_DEFINES_SVH
`define MAX_FRONT_DEQUE_UNIT_DEFINES_SVH

// Concurrent check sampled on the rising clock edge, off while reset is held.
`define MFD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also holds while reset is held.
`define MFD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/mfd_pkg.sv
package mfd_pkg;

    // Default sizes of the store.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the channel fields.
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Operation broadcast to every cell for the beat being accepted.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop;
        logic remove;
    } mfd_ctl_t;

    // Flags rippling from the front cell toward the back cell.
    typedef struct packed {
        logic all_less;
        logic hit;
    } mfd_chain_t;

endpackage

// File: hw/rtl/mfd_cell.sv
module mfd_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int FILL_W     = 5,
    parameter int IDX        = 0
) (
    input  logic                         aclk,
    input  mfd_pkg::mfd_ctl_t            ctl,
    input  logic [FILL_W-1:0]            fill,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic signed [DATA_WIDTH-1:0] left_data,
    input  logic signed [DATA_WIDTH-1:0] right_data,
    input  mfd_pkg::mfd_chain_t          chain_in,
    input  logic [DATA_WIDTH-1:0]        pick_in,
    output mfd_pkg::mfd_chain_t          chain_out,
    output logic [DATA_WIDTH-1:0]        pick_out,
    output logic signed [DATA_WIDTH-1:0] slot
);
    import mfd_pkg::*;

    logic signed [DATA_WIDTH-1:0] slot_reg;
    logic signed [DATA_WIDTH-1:0] slot_next;
    logic                         occupied;
    logic                         own_hit;
    logic                         first_hit;

    // This cell holds a stored value when its position is below the fill count.
    assign occupied = (FILL_W'(IDX) < fill);

    // A pop always targets the front cell; a remove targets equal values.
    assign own_hit   = occupied && ((ctl.pop && (IDX == 0)) ||
                                    (ctl.remove && (slot_reg == value)));
    assign first_hit = own_hit && !chain_in.hit;

    // Ripple the search flags and the picked value toward the back.
    assign chain_out.all_less = chain_in.all_less && (!occupied || (value > slot_reg));
    assign chain_out.hit      = chain_in.hit || own_hit;
    assign pick_out           = first_hit ? (pick_in | slot_reg) : pick_in;

    // Shift toward the back on a front push, write the first free cell on a back push, toward the front behind a drop.
    always_comb begin
        slot_next = slot_reg;
        if (ctl.push_front) begin
            slot_next = left_data;
        end else if (ctl.push_back && (fill == FILL_W'(IDX))) begin
            slot_next = value;
        end else if ((ctl.pop || ctl.remove) && (chain_in.hit || own_hit)) begin
            slot_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

// File: hw/rtl/max_front_deque_unit.sv
// Channel   Direction  Handshake           Fields
// s_        in         s_valid / s_ready   s_operation, s_value
// m_        out        m_valid / m_ready   m_status, m_out_value, m_count, m_is_empty
//
// Each beat is handled by a row of DEPTH cells; the compare and
// first-match flags ripple through the row, so the row length sets the path.
// The result is registered into the output register in the cycle after the input beat.
// A new beat is taken when no result is held or the held result is taken in the same cycle.
// Reset clears the fill count and the output valid; cell contents stay as is.
module max_front_deque_unit
    #(
    parameter int DEPTH      = mfd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mfd_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mfd_pkg::OP_W-1:0]             s_operation,
    input  logic signed [mfd_pkg::VALUE_W-1:0]   s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mfd_pkg::STATUS_W-1:0]         m_status,
    output logic signed [mfd_pkg::VALUE_W-1:0]   m_out_value,
    output logic [mfd_pkg::COUNT_W-1:0]          m_count,
    output logic                                 m_is_empty
);
    import mfd_pkg::*;

    `include "max_front_deque_unit_defines.svh"

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int WIDE_W = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;

    logic                         accept;
    logic signed [DATA_WIDTH-1:0] value_w;
    logic                         full;
    logic                         is_push;
    mfd_ctl_t                     ctl;

    logic [FILL_W-1:0]            fill_reg;
    logic [FILL_W-1:0]            fill_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [STATUS_W-1:0]          status_reg;
    logic [STATUS_W-1:0]          status_next;
    logic signed [VALUE_W-1:0]    out_value_reg;
    logic signed [VALUE_W-1:0]    out_value_next;
    logic [WIDE_W-1:0]            fill_wide;

    mfd_chain_t                   chain [DEPTH+1];
    logic [DATA_WIDTH-1:0]        pick  [DEPTH+1];
    logic signed [DATA_WIDTH-1:0] slots [DEPTH];

    // Input side is free when no result waits or the waiting one leaves now.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Bring the input value to the store width, two's complement.
    assign value_w = DATA_WIDTH'(signed'(s_value));

    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign is_push = (s_operation == OP_PUSH);

    // Decode the beat into the controls shared by all cells.
    assign ctl.push_front = accept && is_push && !full && chain[DEPTH].all_less;
    assign ctl.push_back  = accept && is_push && !full && !chain[DEPTH].all_less;
    assign ctl.pop        = accept && (s_operation == OP_POP);
    assign ctl.remove     = accept && (s_operation == OP_REMOVE);

    // Head of the chain.
    assign chain[0].all_less = 1'b1;
    assign chain[0].hit      = 1'b0;
    assign pick[0]           = '0;

    // Row of cells linked to their neighbors; the front cell takes in the input value.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_d;
        logic signed [DATA_WIDTH-1:0] right_d;

        if (i == 0) begin : g_front
            assign left_d = value_w;
        end else begin : g_inner_l
            assign left_d = slots[i-1];
        end

        if (i == DEPTH - 1) begin : g_back
            assign right_d = slots[i];
        end else begin : g_inner_r
            assign right_d = slots[i+1];
        end

        mfd_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .FILL_W     (FILL_W),
            .IDX        (i)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .fill       (fill_reg),
            .value      (value_w),
            .left_data  (left_d),
            .right_data (right_d),
            .chain_in   (chain[i]),
            .pick_in    (pick[i]),
            .chain_out  (chain[i+1]),
            .pick_out   (pick[i+1]),
            .slot       (slots[i])
        );
    end

    // Next fill count, status and returned value.
    always_comb begin
        fill_next      = fill_reg;
        status_next    = status_reg;
        out_value_next = out_value_reg;
        m_valid_next   = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next   = 1'b1;
            status_next    = ST_MISS;
            out_value_next = '0;
            case (s_operation)
                OP_PUSH: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        status_next = ST_DONE;
                        fill_next   = fill_reg + FILL_W'(1);
                    end
                end
                OP_POP, OP_REMOVE: begin
                    if (chain[DEPTH].hit) begin
                        status_next    = ST_DONE;
                        out_value_next = VALUE_W'(signed'(pick[DEPTH]));
                        fill_next      = fill_reg - FILL_W'(1);
                    end
                end
                default: begin
                    status_next = ST_MISS;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        out_value_reg <= out_value_next;
    end

    // Result outputs.
    assign fill_wide   = WIDE_W'(fill_reg);
    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_out_value = out_value_reg;
    assign m_count     = fill_wide[COUNT_W-1:0];
    assign m_is_empty  = (fill_reg == '0);

    // Checks on the store bookkeeping.
    `MFD_ASSERT_ALWAYS(a_fill_bound, aclk, !aresetn || fill_reg <= FILL_W'(DEPTH), "fill above depth")
    `MFD_ASSERT(a_push_full, aclk, aresetn, (accept && is_push && full) |=> (m_status == ST_FULL && $stable(fill_reg)), "full push not refused")
    `MFD_ASSERT(a_pop_drop, aclk, aresetn, (accept && s_operation == OP_POP && fill_reg != '0) |=> (fill_reg == $past(fill_reg) - FILL_W'(1)), "pop did not drop one value")
    `MFD_ASSERT(a_result_out, aclk, aresetn, accept |=> m_valid, "accepted beat gave no result")

endmodule
